// ===== src/cbm_pkg.sv =====
// cbm_pkg: shared types and constants of the cartridge bank mapper
package cbm_pkg;

    // target memory codes
    localparam logic [1:0] TGT_NONE  = 2'd0;
    localparam logic [1:0] TGT_ROM   = 2'd1;
    localparam logic [1:0] TGT_FLASH = 2'd2;
    localparam logic [1:0] TGT_RAM   = 2'd3;

    // configuration register indexes
    localparam logic CFG_RAM_BANK_MASK = 1'b0;
    localparam logic CFG_RAM_PRESENT   = 1'b1;

    // register field widths
    localparam int ROM_SEL_W  = 8;
    localparam int RAM_SEL_W  = 3;
    localparam int RAM_OFFS_W = 12;   // 4 KiB static RAM page
    localparam int WIN_OFFS_W = 13;   // 8 KiB ROM / Flash window
    localparam int PHYS_W     = 20;

    // control register value that enables static RAM
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    // one bus access
    typedef struct packed {
        logic        req_type;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } cbm_item_t;

    // one mapped access
    typedef struct packed {
        logic [1:0]        target;
        logic              target_write;
        logic [PHYS_W-1:0] phys_address;
        logic [7:0]        data_out;
    } cbm_result_t;

    // configuration registers
    typedef struct packed {
        logic [RAM_SEL_W-1:0] ram_bank_mask;
        logic                 ram_present;
    } cbm_cfg_t;

    // mapper control registers
    typedef struct packed {
        logic [1:0][ROM_SEL_W-1:0] rom_page_sel;
        logic [1:0][RAM_SEL_W-1:0] ram_page_sel;
        logic [1:0]                flash_selected;
        logic                      flash_enabled;
        logic                      flash_write_enabled;
        logic                      ram_enabled;
    } cbm_state_t;

endpackage

// ===== src/cbm_ifs.sv =====
// cbm_req_if and cbm_resp_if: valid/ready channels of the bank mapper
interface cbm_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] bus_address;
    logic [7:0]  write_data;

    modport source (output valid, output req_type, output bus_address,
                    output write_data, input ready);
    modport sink   (input valid, input req_type, input bus_address,
                    input write_data, output ready);
endinterface

interface cbm_resp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  target;
    logic        target_write;
    logic [19:0] phys_address;
    logic [7:0]  data_out;

    modport source (output valid, output target, output target_write,
                    output phys_address, output data_out, input ready);
    modport sink   (input valid, input target, input target_write,
                    input phys_address, input data_out, output ready);
endinterface

// ===== src/cbm_decode.sv =====
// cbm_decode: control register decode and address mapping of one access
module cbm_decode
    import cbm_pkg::*;
#(
    parameter int ROM_PAGE_BITS = 7
) (
    input  cbm_item_t   item,
    input  cbm_cfg_t    cfg,
    input  cbm_state_t  state,
    output cbm_state_t  state_next,
    output cbm_result_t result
);

    localparam logic [6:0] ROM_PAGE_MASK = 7'((1 << ROM_PAGE_BITS) - 1);

    logic [15:0]           addr;
    logic                  is_write;
    logic                  win_bank;
    logic                  ram_bank;
    logic [ROM_SEL_W-1:0]  page;
    logic [6:0]            rom_page;
    logic                  banked;

    assign addr     = item.bus_address;
    assign is_write = item.req_type;
    assign win_bank = addr[13];
    assign ram_bank = addr[12];
    assign page     = state.rom_page_sel[win_bank];
    assign rom_page = page[6:0] & ROM_PAGE_MASK;
    assign banked   = (cfg.ram_bank_mask != '0);

    // control register writes below 0x4000
    always_comb
    begin
        state_next = state;
        if (is_write && addr[15:14] == 2'b00) begin
            if (addr[13:10] == 4'b0000) begin
                state_next.ram_enabled = (item.write_data[3:0] == RAM_ENABLE_KEY);
            end else if (addr[13:12] == 2'b00 && addr[11:10] != 2'b11) begin
                if (banked) begin
                    state_next.ram_page_sel[addr[11]] =
                        item.write_data[RAM_SEL_W-1:0] & cfg.ram_bank_mask;
                end
            end else if (addr[13:10] == 4'b0011) begin
                if (state.flash_write_enabled) begin
                    state_next.flash_enabled = item.write_data[0];
                end
            end else if (addr[13:0] == 14'h1000) begin
                state_next.flash_write_enabled = item.write_data[0];
            end else if (addr[13]) begin
                if (!addr[11]) begin
                    state_next.rom_page_sel[addr[12]] = item.write_data;
                end else begin
                    state_next.flash_selected[addr[12]] = item.write_data[3];
                end
            end
        end
    end

    // target and physical address
    always_comb
    begin
        result.target       = TGT_NONE;
        result.target_write = 1'b0;
        result.phys_address = '0;
        if (addr[15:14] == 2'b00) begin
            // fixed first 16 KiB of ROM, writes go to the control registers
            if (!is_write) begin
                result.target       = TGT_ROM;
                result.phys_address = PHYS_W'(addr[13:0]);
            end
        end else if (addr[15:14] == 2'b01) begin
            // switchable ROM / Flash windows
            if (state.flash_selected[win_bank]) begin
                if (state.flash_enabled) begin
                    result.target       = TGT_FLASH;
                    result.target_write = is_write;
                    result.phys_address = {page[6:0], addr[WIN_OFFS_W-1:0]};
                end
            end else if (!page[7] && !is_write) begin
                result.target       = TGT_ROM;
                result.phys_address = {rom_page, addr[WIN_OFFS_W-1:0]};
            end
        end else if (addr[15:13] == 3'b101) begin
            // static RAM windows
            if (cfg.ram_present && state.ram_enabled) begin
                result.target       = TGT_RAM;
                result.target_write = is_write;
                if (banked) begin
                    result.phys_address = PHYS_W'({state.ram_page_sel[ram_bank],
                                                   addr[RAM_OFFS_W-1:0]});
                end else begin
                    result.phys_address = PHYS_W'(addr[RAM_OFFS_W-1:0]);
                end
            end
        end
        result.data_out = result.target_write ? item.write_data : 8'd0;
    end

endmodule

// ===== src/cartridge_bank_mapper_core.sv =====
// cartridge_bank_mapper_core: top level of the cartridge bank mapper
//
//  channel  dir  payload                                           transfer when
//  req      in   req_type, bus_address, write_data                 valid && ready
//  resp     out  target, target_write, phys_address, data_out      valid && ready
//  cfg      in   cfg_index, cfg_data                               cfg_we
//
// one access a cycle while results are taken; a result passes through the
// input register, then decode into the result register
// control registers change as an access leaves the input register, so
// accesses see them in order
// reset clears control registers, configuration and both valid flags
// a stalled result holds the input register; req.ready drops only then
module cartridge_bank_mapper_core
    import cbm_pkg::*;
#(
    parameter int ROM_PAGE_BITS = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [RAM_SEL_W-1:0] cfg_data,
    cbm_req_if.sink              req,
    cbm_resp_if.source           resp
);

    cbm_cfg_t    cfg_reg;
    cbm_state_t  state_reg;
    cbm_state_t  state_next;
    logic        in_valid_reg;
    cbm_item_t   item_reg;
    logic        out_valid_reg;
    cbm_result_t result_reg;
    cbm_result_t result_next;
    logic        advance;

    // pipeline flow
    assign advance   = in_valid_reg && (!out_valid_reg || resp.ready);
    assign req.ready = !in_valid_reg || advance;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RAM_BANK_MASK: cfg_reg.ram_bank_mask <= cfg_data;
                CFG_RAM_PRESENT:   cfg_reg.ram_present   <= cfg_data[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // access decode
    cbm_decode #(
        .ROM_PAGE_BITS (ROM_PAGE_BITS)
    ) u_decode (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // control state and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (req.ready) begin
                in_valid_reg <= req.valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (resp.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) begin
            item_reg.req_type    <= req.req_type;
            item_reg.bus_address <= req.bus_address;
            item_reg.write_data  <= req.write_data;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    // result port
    assign resp.valid        = out_valid_reg;
    assign resp.target       = result_reg.target;
    assign resp.target_write = result_reg.target_write;
    assign resp.phys_address = result_reg.phys_address;
    assign resp.data_out     = result_reg.data_out;

`ifndef NO_ASSERTIONS
    // unmapped accesses carry a zero address
    a_none_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (resp.valid && resp.target == TGT_NONE) |-> (resp.phys_address == '0))
        else $error("unmapped result with non-zero address");

    // data only with a memory write
    a_data_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (resp.valid && !resp.target_write) |-> (resp.data_out == 8'd0))
        else $error("data passed without a write");

    // only Flash and RAM take writes
    a_write_target: assert property (@(posedge clk) disable iff (!rst_n)
        (resp.valid && resp.target_write) |->
            (resp.target == TGT_FLASH || resp.target == TGT_RAM))
        else $error("write to read-only or unmapped target");

    // a held result and a full input register block new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && resp.valid && !resp.ready) |-> !req.ready)
        else $error("request taken while pipeline stalled");

    // Flash enable only changes under Flash write enable
    a_flash_enable: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.flash_enabled) |-> $past(state_reg.flash_write_enabled))
        else $error("Flash enabled without write enable");
`endif

endmodule
